### rtl/core/mfep_pkg.sv
`default_nettype none

package mfep_pkg;

	localparam logic [31:0] TAG_HEADER = 32'h4d54_6864;
	localparam logic [31:0] TAG_TRACK  = 32'h4d54_726b;
	localparam logic [31:0] HDR_MIN_LEN = 32'd6;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_EVENT  = 2'd1;
	localparam logic [1:0] KIND_TEXT   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [23:0] ERR_HDR_TAG = 24'd0;
	localparam logic [23:0] ERR_HDR_LEN = 24'd1;
	localparam logic [23:0] ERR_TRK_TAG = 24'd2;

	localparam logic [3:0] ST_NOTE_ON = 4'h9;
	localparam logic [3:0] ST_PROGRAM = 4'hC;
	localparam logic [3:0] ST_SYSTEM  = 4'hF;

	localparam logic [7:0] META_TEXT_LO = 8'h01;
	localparam logic [7:0] META_TEXT_HI = 8'h05;
	localparam logic [7:0] META_EOT     = 8'h2F;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [7:0] META_TIMESIG = 8'h58;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} src_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] delta_time;
		logic [31:0] abs_time;
		logic [7:0]  command;
		logic [3:0]  channel;
		logic [7:0]  meta_type;
		logic [23:0] value;
		logic [7:0]  data_a;
		logic [7:0]  data_b;
		logic [7:0]  data_c;
		logic [7:0]  data_d;
		logic [14:0] division;
	} evt_word_t;

	typedef enum logic [21:0] {
		PH_HTAG      = 22'd1 << 0,
		PH_HLEN      = 22'd1 << 1,
		PH_HFMT      = 22'd1 << 2,
		PH_HTRK      = 22'd1 << 3,
		PH_HDIV      = 22'd1 << 4,
		PH_HSKIP     = 22'd1 << 5,
		PH_TTAG      = 22'd1 << 6,
		PH_TLEN      = 22'd1 << 7,
		PH_DELTA     = 22'd1 << 8,
		PH_STATUS    = 22'd1 << 9,
		PH_NOTE_A    = 22'd1 << 10,
		PH_NOTE_B    = 22'd1 << 11,
		PH_PROG      = 22'd1 << 12,
		PH_MTYPE     = 22'd1 << 13,
		PH_TEXT_LEN  = 22'd1 << 14,
		PH_TEXT      = 22'd1 << 15,
		PH_EOT_LEN   = 22'd1 << 16,
		PH_TEMPO_LEN = 22'd1 << 17,
		PH_TEMPO     = 22'd1 << 18,
		PH_SIG_LEN   = 22'd1 << 19,
		PH_SIG       = 22'd1 << 20,
		PH_HALT      = 22'd1 << 21
	} phase_t;

endpackage

`default_nettype wire

### rtl/core/midi_file_event_parser.sv
// midi file event parser
// src channel: one byte of a standard midi file per word (data_byte), with
// last_byte marking the final byte of the file; after it a new file header
// is expected, while the running track time carries on.
// evt channel: at most one result word per input byte: header info, channel
// or meta event, text byte, or error code. after an error the parser drops
// bytes until a word marked last_byte.
// both channels use valid/stall; a word moves when valid is high and stall
// is low.
// a byte accepted from src is held in the input register, and its result word
// is registered in the result register that drives evt.
// throughput: one byte per cycle while src_stall stays low; the phase machine
// and its accumulators sit between the input register and the result
// register.
// when evt is stalled with a result waiting, a byte that causes no result
// still goes through; a byte that does cause one waits in the input
// register and src_stall rises.
// reset clears the phase machine, counters and running time and empties
// both registers.

`default_nettype none

module midi_file_event_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  mfep_pkg::src_word_t src_word,
	output logic                evt_valid,
	input  logic                evt_stall,
	output mfep_pkg::evt_word_t evt_word
);
	import mfep_pkg::*;

	logic      src_valid_s1;
	src_word_t src_word_s1;
	logic      evt_valid_s2;
	evt_word_t evt_word_s2;

	logic      advance;
	logic      emit;
	logic      evt_free;
	evt_word_t result;

	mfep_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (src_word_s1),
		.emit   (emit),
		.result (result)
	);

	assign evt_free  = !evt_valid_s2 || !evt_stall;
	assign advance   = src_valid_s1 && (evt_free || !emit);
	assign src_stall = src_valid_s1 && !advance;
	assign evt_valid = evt_valid_s2;
	assign evt_word  = evt_word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			src_valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			src_word_s1 <= src_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			evt_valid_s2 <= 1'b1;
		end else if (!evt_stall) begin
			evt_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			evt_word_s2 <= result;
		end
	end

`ifndef SYNTHESIS
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> evt_valid)
		else $error("result word lost");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_word.kind == KIND_ERROR |-> evt_word.value < 24'd3)
		else $error("error word with bad code");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_word.kind == KIND_HEADER
		|-> evt_word.delta_time == 32'd0 && evt_word.command == 8'd0)
		else $error("header word carries event fields");
`endif

endmodule

`default_nettype wire

### rtl/core/mfep_core.sv
`default_nettype none

module mfep_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  mfep_pkg::src_word_t item,
	output logic                emit,
	output mfep_pkg::evt_word_t result
);
	import mfep_pkg::*;

	phase_t      phase_q, phase_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [31:0] gw_q, gw_n;
	logic [31:0] delta_q, delta_n;
	logic [31:0] rt_q, rt_n;
	logic [31:0] extra_q, extra_n;
	logic [7:0]  status_q, status_n;
	logic [7:0]  meta_q, meta_n;
	logic [7:0]  hb0_q, hb0_n;
	logic [7:0]  hb1_q, hb1_n;
	logic [7:0]  hb2_q, hb2_n;
	logic [7:0]  txt_q, txt_n;
	logic [15:0] fmt_q, fmt_n;
	logic [15:0] trk_q, trk_n;

	logic [7:0]  b;
	logic [31:0] gw_sh;
	logic [31:0] delta_sh;
	logic [1:0]  cnt_inc;
	logic        done2, done3, done4;
	logic [7:0]  cur_status;
	logic [7:0]  cur_meta;
	logic        sys;
	evt_word_t   ev;

	assign b        = item.data_byte;
	assign gw_sh    = {gw_q[23:0], b};
	assign delta_sh = {delta_q[24:0], b[6:0]};
	assign cnt_inc  = cnt_q + 2'd1;
	assign done2    = (cnt_q == 2'd1);
	assign done3    = (cnt_q == 2'd2);
	assign done4    = (cnt_q == 2'd3);

	assign cur_status = (phase_q == PH_STATUS) ? b : status_q;
	assign cur_meta   = (phase_q == PH_STATUS) ? 8'd0 :
	                    (phase_q == PH_MTYPE)  ? b : meta_q;
	assign sys        = (cur_status[7:4] == ST_SYSTEM);

	always_comb begin
		ev            = '0;
		ev.kind       = KIND_EVENT;
		ev.delta_time = delta_q;
		ev.abs_time   = rt_q;
		ev.command    = cur_status;
		ev.channel    = sys ? 4'd0 : cur_status[3:0];
		ev.meta_type  = sys ? cur_meta : 8'd0;
	end

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		gw_n     = gw_q;
		delta_n  = delta_q;
		rt_n     = rt_q;
		extra_n  = extra_q;
		status_n = status_q;
		meta_n   = meta_q;
		hb0_n    = hb0_q;
		hb1_n    = hb1_q;
		hb2_n    = hb2_q;
		txt_n    = txt_q;
		fmt_n    = fmt_q;
		trk_n    = trk_q;
		emit     = 1'b0;
		result   = '0;

		unique case (phase_q)
			PH_HTAG: begin
				gw_n  = gw_sh;
				cnt_n = done4 ? 2'd0 : cnt_inc;
				if (done4) begin
					if (gw_sh != TAG_HEADER) begin
						emit         = 1'b1;
						result.kind  = KIND_ERROR;
						result.value = ERR_HDR_TAG;
						phase_n      = PH_HALT;
					end else begin
						phase_n = PH_HLEN;
					end
				end
			end
			PH_HLEN: begin
				gw_n  = gw_sh;
				cnt_n = done4 ? 2'd0 : cnt_inc;
				if (done4) begin
					if (gw_sh < HDR_MIN_LEN) begin
						emit         = 1'b1;
						result.kind  = KIND_ERROR;
						result.value = ERR_HDR_LEN;
						phase_n      = PH_HALT;
					end else begin
						extra_n = gw_sh - HDR_MIN_LEN;
						phase_n = PH_HFMT;
					end
				end
			end
			PH_HFMT: begin
				gw_n  = gw_sh;
				cnt_n = done2 ? 2'd0 : cnt_inc;
				if (done2) begin
					fmt_n   = gw_sh[15:0];
					phase_n = PH_HTRK;
				end
			end
			PH_HTRK: begin
				gw_n  = gw_sh;
				cnt_n = done2 ? 2'd0 : cnt_inc;
				if (done2) begin
					trk_n   = gw_sh[15:0];
					phase_n = PH_HDIV;
				end
			end
			PH_HDIV: begin
				gw_n  = gw_sh;
				cnt_n = done2 ? 2'd0 : cnt_inc;
				if (done2) begin
					emit            = 1'b1;
					result.kind     = KIND_HEADER;
					result.value    = {8'd0, trk_q};
					result.data_a   = fmt_q[7:0];
					result.data_b   = {7'd0, gw_sh[15]};
					result.division = gw_sh[14:0];
					phase_n         = (extra_q != 32'd0) ? PH_HSKIP : PH_TTAG;
				end
			end
			PH_HSKIP: begin
				extra_n = extra_q - 32'd1;
				if (extra_q == 32'd1) begin
					phase_n = PH_TTAG;
				end
			end
			PH_TTAG: begin
				gw_n  = gw_sh;
				cnt_n = done4 ? 2'd0 : cnt_inc;
				if (done4) begin
					if (gw_sh != TAG_TRACK) begin
						emit         = 1'b1;
						result.kind  = KIND_ERROR;
						result.value = ERR_TRK_TAG;
						phase_n      = PH_HALT;
					end else begin
						phase_n = PH_TLEN;
					end
				end
			end
			PH_TLEN: begin
				gw_n  = gw_sh;
				cnt_n = done4 ? 2'd0 : cnt_inc;
				if (done4) begin
					delta_n = 32'd0;
					phase_n = PH_DELTA;
				end
			end
			PH_DELTA: begin
				delta_n = delta_sh;
				if (!b[7]) begin
					rt_n    = rt_q + delta_sh;
					phase_n = PH_STATUS;
				end
			end
			PH_STATUS: begin
				status_n = b;
				meta_n   = 8'd0;
				case (b[7:4])
					ST_NOTE_ON: phase_n = PH_NOTE_A;
					ST_PROGRAM: phase_n = PH_PROG;
					ST_SYSTEM:  phase_n = PH_MTYPE;
					default: begin
						emit    = 1'b1;
						result  = ev;
						delta_n = 32'd0;
						phase_n = PH_DELTA;
					end
				endcase
			end
			PH_NOTE_A: begin
				hb0_n   = b;
				phase_n = PH_NOTE_B;
			end
			PH_NOTE_B: begin
				hb1_n         = b;
				emit          = 1'b1;
				result        = ev;
				result.data_a = hb0_q;
				result.data_b = b;
				delta_n       = 32'd0;
				phase_n       = PH_DELTA;
			end
			PH_PROG: begin
				hb0_n         = b;
				emit          = 1'b1;
				result        = ev;
				result.data_a = b;
				delta_n       = 32'd0;
				phase_n       = PH_DELTA;
			end
			PH_MTYPE: begin
				meta_n = b;
				if (b >= META_TEXT_LO && b <= META_TEXT_HI) begin
					phase_n = PH_TEXT_LEN;
				end else if (b == META_EOT) begin
					phase_n = PH_EOT_LEN;
				end else if (b == META_TEMPO) begin
					phase_n = PH_TEMPO_LEN;
				end else if (b == META_TIMESIG) begin
					phase_n = PH_SIG_LEN;
				end else begin
					emit    = 1'b1;
					result  = ev;
					delta_n = 32'd0;
					phase_n = PH_DELTA;
				end
			end
			PH_TEXT_LEN: begin
				txt_n        = b;
				emit         = 1'b1;
				result       = ev;
				result.value = {16'd0, b};
				if (b == 8'd0) begin
					delta_n = 32'd0;
					phase_n = PH_DELTA;
				end else begin
					phase_n = PH_TEXT;
				end
			end
			PH_TEXT: begin
				emit          = 1'b1;
				result        = ev;
				result.kind   = KIND_TEXT;
				result.data_a = b;
				txt_n         = txt_q - 8'd1;
				if (txt_q == 8'd1) begin
					delta_n = 32'd0;
					phase_n = PH_DELTA;
				end
			end
			PH_EOT_LEN: begin
				cnt_n   = 2'd0;
				phase_n = PH_TTAG;
			end
			PH_TEMPO_LEN: begin
				cnt_n   = 2'd0;
				phase_n = PH_TEMPO;
			end
			PH_TEMPO: begin
				gw_n  = gw_sh;
				cnt_n = done3 ? 2'd0 : cnt_inc;
				if (done3) begin
					emit         = 1'b1;
					result       = ev;
					result.value = gw_sh[23:0];
					delta_n      = 32'd0;
					phase_n      = PH_DELTA;
				end
			end
			PH_SIG_LEN: begin
				cnt_n   = 2'd0;
				phase_n = PH_SIG;
			end
			PH_SIG: begin
				gw_n  = gw_sh;
				cnt_n = done4 ? 2'd0 : cnt_inc;
				case (cnt_q)
					2'd0:    hb0_n = b;
					2'd1:    hb1_n = b;
					2'd2:    hb2_n = b;
					default: ;
				endcase
				if (done4) begin
					emit          = 1'b1;
					result        = ev;
					result.data_a = hb0_q;
					result.data_b = hb1_q;
					result.data_c = hb2_q;
					result.data_d = b;
					delta_n       = 32'd0;
					phase_n       = PH_DELTA;
				end
			end
			PH_HALT: ;
			default: phase_n = PH_HALT;
		endcase

		// end of file: drop any partial item, running time is kept
		if (item.last_byte) begin
			phase_n = PH_HTAG;
			cnt_n   = 2'd0;
			gw_n    = 32'd0;
			delta_n = 32'd0;
			txt_n   = 8'd0;
			extra_n = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HTAG;
			cnt_q    <= 2'd0;
			gw_q     <= 32'd0;
			delta_q  <= 32'd0;
			rt_q     <= 32'd0;
			extra_q  <= 32'd0;
			status_q <= 8'd0;
			meta_q   <= 8'd0;
			hb0_q    <= 8'd0;
			hb1_q    <= 8'd0;
			hb2_q    <= 8'd0;
			txt_q    <= 8'd0;
			fmt_q    <= 16'd0;
			trk_q    <= 16'd0;
		end else if (advance) begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			gw_q     <= gw_n;
			delta_q  <= delta_n;
			rt_q     <= rt_n;
			extra_q  <= extra_n;
			status_q <= status_n;
			meta_q   <= meta_n;
			hb0_q    <= hb0_n;
			hb1_q    <= hb1_n;
			hb2_q    <= hb2_n;
			txt_q    <= txt_n;
			fmt_q    <= fmt_n;
			trk_q    <= trk_n;
		end
	end

`ifndef SYNTHESIS
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.last_byte |=> phase_q == PH_HTAG)
		else $error("parser not back at header tag after last byte");

	a_text_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TEXT |-> txt_q != 8'd0)
		else $error("text phase with no bytes left");

	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HSKIP |-> extra_q != 32'd0)
		else $error("header skip phase with no bytes left");
`endif

endmodule

`default_nettype wire
